// ===== sv/tws_pkg.sv =====
// ---------------------------------------------------------------------------
// tws_pkg: shared types and constants of the toroidal window store
// Opcodes, sequencer states and the item structs of both channels.
// ---------------------------------------------------------------------------
package tws_pkg;

   localparam int unsigned CW = 16;
   localparam int unsigned DW = 32;

   typedef enum logic [2:0] {
      OP_READ  = 3'd0,
      OP_WRITE = 3'd1,
      OP_FILL  = 3'd2,
      OP_SHIFT = 3'd3,
      OP_MOVE  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_SIZE_X  = 2'd0,
      CSR_SIZE_Y  = 2'd1,
      CSR_SIZE_Z  = 2'd2,
      CSR_DEFAULT = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]    opcode;
      logic [CW-1:0] coord_x;
      logic [CW-1:0] coord_y;
      logic [CW-1:0] coord_z;
      logic [CW-1:0] box_high_x;
      logic [CW-1:0] box_high_y;
      logic [CW-1:0] box_high_z;
      logic [DW-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [DW-1:0] read_value;
      logic [CW-1:0] origin_x;
      logic [CW-1:0] origin_y;
      logic [CW-1:0] origin_z;
   } rsp_type;

endpackage

// ===== sv/tws_ram.sv =====
// ---------------------------------------------------------------------------
// tws_ram: generic single-port RAM
// One address per cycle, written when wr_en is high and always read; read data is registered.
// ---------------------------------------------------------------------------
module tws_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
endmodule

// ===== sv/toroidal_window_store.sv =====
// ---------------------------------------------------------------------------
// toroidal_window_store: wrapping 3-D window store
// Slot memory with read, write, box fill and window shift/move.
// ---------------------------------------------------------------------------
// The slot data lives in one single-port RAM of 2^(3*MAX_SIZE_LOG2) words.
// After reset a clearing pass writes zero to every word, one a cycle;
// req_stall stays high meanwhile. A read passes through the RAM address,
// the registered read and the result register; a write goes to the RAM
// on acceptance. A fill visits one slot a cycle over its clamped box.
// A shift or move walks three slabs, one slot a cycle, each slab's length
// being the product of its clamped counts; an empty slab is skipped without
// writing. One item is worked at a time; the result sits in an output
// register until taken, and the next item is accepted once that register
// is free. Every item gives one result carrying the origin after the item;
// read_value is zero except for reads. Size registers above MAX_SIZE_LOG2
// act as MAX_SIZE_LOG2.
module toroidal_window_store #(
   parameter int unsigned MAX_SIZE_LOG2 = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  tws_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output tws_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_data
);
   localparam int unsigned DATA_WIDTH  = tws_pkg::DW;
   localparam int unsigned COORD_WIDTH = tws_pkg::CW;
   localparam int unsigned AW = 3 * MAX_SIZE_LOG2;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned CNT_W = MAX_SIZE_LOG2 + 1;
   localparam int unsigned LGW = $clog2(MAX_SIZE_LOG2 + 1);

   // configuration
   logic [2:0]            size_x_ff, size_y_ff, size_z_ff;
   logic [DATA_WIDTH-1:0] default_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= 3'd4;
         size_y_ff  <= 3'd4;
         size_z_ff  <= 3'd0;
         default_ff <= '0;
      end else if (csr_valid) begin
         unique case (tws_pkg::csr_type'(csr_index))
            tws_pkg::CSR_SIZE_X:  size_x_ff  <= csr_data[2:0];
            tws_pkg::CSR_SIZE_Y:  size_y_ff  <= csr_data[2:0];
            tws_pkg::CSR_SIZE_Z:  size_z_ff  <= csr_data[2:0];
            tws_pkg::CSR_DEFAULT: default_ff <= csr_data[DATA_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // clamp a size register to the memory's extent
   function automatic logic [LGW-1:0] eff_lg(input logic [2:0] v);
      logic [LGW-1:0] r;
      if (32'(v) > MAX_SIZE_LOG2) r = LGW'(MAX_SIZE_LOG2);
      else                          r = LGW'(v);
      return r;
   endfunction

   logic [LGW-1:0] lg [3];
   logic [CNT_W-1:0] sz [3];
   assign lg[0] = eff_lg(size_x_ff);
   assign lg[1] = eff_lg(size_y_ff);
   assign lg[2] = eff_lg(size_z_ff);
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         sz[d] = CNT_W'(1) << lg[d];
      end
   end

   // state
   tws_pkg::state_type   state_ff, state_in;
   logic [COORD_WIDTH-1:0] org_ff [3];
   logic [COORD_WIDTH-1:0] org_in [3];
   logic [COORD_WIDTH-1:0] amt_ff [3];
   logic [COORD_WIDTH-1:0] start_ff [3];
   logic [CNT_W-1:0]       cnt_ff [3];
   logic [CNT_W-1:0]       ch_ff [3];
   logic [CNT_W-1:0]       i_ff [3];
   logic [1:0]             slab_ff;
   logic                   is_shift_ff;
   logic [DATA_WIDTH-1:0]  wval_ff;
   logic [AW-1:0]          clr_ff;
   logic                   rsp_valid_ff;
   tws_pkg::rsp_type       rsp_ff;

   tws_pkg::req_type rq;
   assign rq = req_data;

   logic accept;
   assign req_stall = (state_ff != tws_pkg::ST_IDLE) || rsp_valid_ff;
   assign accept = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // slot address of a coordinate triple
   function automatic logic [AW-1:0] slot_of(
      input logic [COORD_WIDTH-1:0] cx, cy, cz,
      input logic [LGW-1:0] l0, l1, l2);
      logic [AW-1:0] mx, my, mz;
      mx = AW'(cx) & ((AW'(1) << l0) - AW'(1));
      my = AW'(cy) & ((AW'(1) << l1) - AW'(1));
      mz = AW'(cz) & ((AW'(1) << l2) - AW'(1));
      return mx | (my << l0) | (mz << ({1'b0, l0} + {1'b0, l1}));
   endfunction

   // slab setup for a shift: slab s clears dims j<s tail, j==s head
   logic [COORD_WIDTH-1:0] sl_start [3];
   logic [CNT_W-1:0]       sl_cnt [3];
   logic                   sl_empty;
   logic [1:0]             sl_sel;
   always_comb begin
      sl_empty = 1'b0;
      for (int j = 0; j < 3; j++) begin
         if (2'(j) < sl_sel) begin
            sl_start[j] = org_ff[j] + COORD_WIDTH'(ch_ff[j]);
            sl_cnt[j]   = sz[j] - ch_ff[j];
         end else if (2'(j) == sl_sel) begin
            sl_start[j] = org_ff[j];
            sl_cnt[j]   = ch_ff[j];
         end else begin
            sl_start[j] = org_ff[j];
            sl_cnt[j]   = sz[j];
         end
         if (sl_cnt[j] == '0) sl_empty = 1'b1;
      end
   end

   // amounts of the incoming item, clamped for clearing
   logic [COORD_WIDTH-1:0] in_c [3];
   logic [COORD_WIDTH-1:0] in_h [3];
   logic [COORD_WIDTH-1:0] in_amt [3];
   logic [CNT_W-1:0]       in_ch [3];
   logic [CNT_W-1:0]       fill_cnt [3];
   logic                   fill_empty;
   assign in_c[0] = rq.coord_x;
   assign in_c[1] = rq.coord_y;
   assign in_c[2] = rq.coord_z;
   assign in_h[0] = rq.box_high_x;
   assign in_h[1] = rq.box_high_y;
   assign in_h[2] = rq.box_high_z;
   always_comb begin
      logic [COORD_WIDTH:0] n;
      fill_empty = 1'b0;
      for (int d = 0; d < 3; d++) begin
         if (rq.opcode == tws_pkg::OP_MOVE) in_amt[d] = in_c[d] - org_ff[d];
         else                               in_amt[d] = in_c[d];
         if ({1'b0, in_amt[d]} < (COORD_WIDTH+1)'(sz[d])) in_ch[d] = CNT_W'(in_amt[d]);
         else                                             in_ch[d] = sz[d];
         if (in_c[d] > in_h[d]) fill_empty = 1'b1;
         n = {1'b0, in_h[d]} - {1'b0, in_c[d]} + (COORD_WIDTH+1)'(1);
         if (n < (COORD_WIDTH+1)'(sz[d])) fill_cnt[d] = CNT_W'(n);
         else                             fill_cnt[d] = sz[d];
      end
   end

   // walker: innermost dimension z, then y, then x
   logic last_z, last_y, last_x, walk_last;
   assign last_z = (i_ff[2] + CNT_W'(1)) == cnt_ff[2];
   assign last_y = (i_ff[1] + CNT_W'(1)) == cnt_ff[1];
   assign last_x = (i_ff[0] + CNT_W'(1)) == cnt_ff[0];
   assign walk_last = last_x && last_y && last_z;
   logic slabs_done;
   assign slabs_done = !is_shift_ff || (slab_ff == 2'd2);

   // set up the slab after the current one
   assign sl_sel = (state_ff == tws_pkg::ST_IDLE) ? 2'd0 : slab_ff + 2'd1;

   // next state
   logic next_empty_run;
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tws_pkg::ST_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = tws_pkg::ST_IDLE;
         tws_pkg::ST_IDLE: begin
            if (accept) begin
               case (rq.opcode)
                  tws_pkg::OP_READ:  state_in = tws_pkg::ST_READ;
                  tws_pkg::OP_FILL:
                     state_in = fill_empty ? tws_pkg::ST_DONE : tws_pkg::ST_WALK;
                  tws_pkg::OP_SHIFT, tws_pkg::OP_MOVE: state_in = tws_pkg::ST_WALK;
                  default:           state_in = tws_pkg::ST_DONE;
               endcase
            end
         end
         tws_pkg::ST_READ: state_in = tws_pkg::ST_DONE;
         tws_pkg::ST_WALK:
            if ((walk_last || next_empty_run) && slabs_done) state_in = tws_pkg::ST_DONE;
         tws_pkg::ST_DONE: state_in = tws_pkg::ST_IDLE;
         default: state_in = tws_pkg::ST_IDLE;
      endcase
   end

   // current walk slab is empty: skip it without writing
   assign next_empty_run = is_shift_ff &&
                           (cnt_ff[0] == '0 || cnt_ff[1] == '0 || cnt_ff[2] == '0);

   // RAM port
   logic                  ram_we;
   logic [AW-1:0]         ram_addr;
   logic [DATA_WIDTH-1:0] ram_wd;
   logic [DATA_WIDTH-1:0] ram_rd;
   logic [COORD_WIDTH-1:0] wc [3];

   always_comb begin
      for (int d = 0; d < 3; d++) wc[d] = start_ff[d] + COORD_WIDTH'(i_ff[d]);
   end

   always_comb begin
      ram_we   = 1'b0;
      ram_wd   = wval_ff;
      ram_addr = slot_of(wc[0], wc[1], wc[2], lg[0], lg[1], lg[2]);
      unique case (state_ff)
         tws_pkg::ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_wd   = '0;
            ram_addr = clr_ff;
         end
         tws_pkg::ST_IDLE: begin
            ram_addr = slot_of(rq.coord_x, rq.coord_y, rq.coord_z, lg[0], lg[1], lg[2]);
            ram_wd   = rq.write_value;
            ram_we   = accept && (rq.opcode == tws_pkg::OP_WRITE);
         end
         tws_pkg::ST_WALK: ram_we = !next_empty_run;
         default: ;
      endcase
   end

   tws_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .addr       (ram_addr),
      .wr_data    (ram_wd),
      .rd_data_ff (ram_rd)
   );

   // origin after the item
   always_comb begin
      for (int d = 0; d < 3; d++) org_in[d] = org_ff[d] + amt_ff[d];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tws_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < 3; d++) org_ff[d] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tws_pkg::ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (accept) begin
            is_shift_ff <= (rq.opcode == tws_pkg::OP_SHIFT) || (rq.opcode == tws_pkg::OP_MOVE);
            slab_ff     <= 2'd0;
            rsp_ff.read_value <= '0;
            for (int d = 0; d < 3; d++) begin
               i_ff[d] <= '0;
               if ((rq.opcode == tws_pkg::OP_SHIFT) || (rq.opcode == tws_pkg::OP_MOVE)) begin
                  amt_ff[d] <= in_amt[d];
                  ch_ff[d]  <= in_ch[d];
                  // first slab: dim 0 head, others full
                  start_ff[d] <= org_ff[d];
                  cnt_ff[d]   <= (d == 0) ? in_ch[d] : sz[d];
               end else begin
                  amt_ff[d]   <= '0;
                  start_ff[d] <= in_c[d];
                  cnt_ff[d]   <= fill_cnt[d];
               end
            end
            wval_ff <= ((rq.opcode == tws_pkg::OP_SHIFT) || (rq.opcode == tws_pkg::OP_MOVE))
                       ? default_ff : rq.write_value;
         end
         if (state_ff == tws_pkg::ST_WALK) begin
            if (walk_last || next_empty_run) begin
               // advance to the next slab
               slab_ff <= slab_ff + 2'd1;
               for (int d = 0; d < 3; d++) begin
                  i_ff[d]     <= '0;
                  start_ff[d] <= sl_start[d];
                  cnt_ff[d]   <= sl_empty ? '0 : sl_cnt[d];
               end
            end else if (!last_z) begin
               i_ff[2] <= i_ff[2] + CNT_W'(1);
            end else if (!last_y) begin
               i_ff[2] <= '0;
               i_ff[1] <= i_ff[1] + CNT_W'(1);
            end else begin
               i_ff[2] <= '0;
               i_ff[1] <= '0;
               i_ff[0] <= i_ff[0] + CNT_W'(1);
            end
         end
         if (state_ff == tws_pkg::ST_READ) rsp_ff.read_value <= ram_rd;
         if (state_ff == tws_pkg::ST_DONE) begin
            rsp_valid_ff <= 1'b1;
            for (int d = 0; d < 3; d++) org_ff[d] <= org_in[d];
            rsp_ff.origin_x <= org_in[0];
            rsp_ff.origin_y <= org_in[1];
            rsp_ff.origin_z <= org_in[2];
         end
      end
   end

   // assertions
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tws_pkg::ST_IDLE) |-> !accept)
      else $error("item accepted while busy");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tws_pkg::ST_DONE) |=> rsp_valid_ff)
      else $error("finished item gave no result");
   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tws_pkg::ST_READ) |-> !ram_we)
      else $error("memory written during read");
   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tws_pkg::ST_CLEAR) |-> req_stall)
      else $error("input open during clearing pass");
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench of the toroidal window store
// Drives a directed table of operations and then random traffic through the
// item channel, models the slot store and window origin in SystemVerilog,
// and checks every result item field by field against the predicted queue.
// Size and default registers are rewritten between phases while idle.
// ---------------------------------------------------------------------------
module testbench;

   localparam int unsigned MAXLG     = 4;
   localparam int unsigned DEPTH     = 1 << (3 * MAXLG);
   localparam int unsigned CYCLE_MAX = 20000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tws_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tws_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = '0;
   logic [31:0]      csr_data = '0;

   toroidal_window_store dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Shadow of the block: slot contents, origin and register file.
   logic [31:0] slot_mem [DEPTH];
   logic [15:0] origin [3];
   logic [2:0]  size_reg [3];
   logic [31:0] clear_value;

   tws_pkg::rsp_type pending_rsp [$];
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;
   bit          hold_off = 1'b0;   // long receiver stall requested by stimulus
   bit          no_gaps = 1'b0;    // stretch of back-to-back traffic

   // Effective log2 extent of one dimension, clamped to the maximum.
   function automatic int unsigned eff_lg(int d);
      return (size_reg[d] > MAXLG) ? MAXLG : size_reg[d];
   endfunction

   function automatic int unsigned slot_of(int unsigned cx, int unsigned cy,
                                           int unsigned cz);
      int unsigned lx, ly, lz;
      lx = eff_lg(0);
      ly = eff_lg(1);
      lz = eff_lg(2);
      return ((cx & ((1 << lx) - 1)) | ((cy & ((1 << ly) - 1)) << lx)
              | ((cz & ((1 << lz) - 1)) << (lx + ly))) & (DEPTH - 1);
   endfunction

   function automatic void paint_box(int unsigned st [3], int unsigned cnt [3],
                                     logic [31:0] value);
      for (int unsigned i = 0; i < cnt[0]; i++)
         for (int unsigned j = 0; j < cnt[1]; j++)
            for (int unsigned k = 0; k < cnt[2]; k++)
               slot_mem[slot_of(st[0] + i, st[1] + j, st[2] + k)] = value;
   endfunction

   // Clear the slabs leaving the window, then advance the origin.
   function automatic void slide_window(int unsigned amt [3]);
      int unsigned sz [3], ch [3], st [3], cnt [3];
      for (int d = 0; d < 3; d++) begin
         sz[d] = 1 << eff_lg(d);
         ch[d] = (amt[d] < sz[d]) ? amt[d] : sz[d];
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (j < i) begin
               st[j] = origin[j] + ch[j];
               cnt[j] = sz[j] - ch[j];
            end else if (j == i) begin
               st[j] = origin[j];
               cnt[j] = ch[j];
            end else begin
               st[j] = origin[j];
               cnt[j] = sz[j];
            end
         end
         paint_box(st, cnt, clear_value);
      end
      for (int d = 0; d < 3; d++) origin[d] = origin[d] + amt[d][15:0];
   endfunction

   // Apply one operation to the shadow and return the predicted result.
   function automatic tws_pkg::rsp_type window_op(tws_pkg::req_type r);
      tws_pkg::rsp_type res;
      int unsigned lo [3], hi [3], st [3], cnt [3], amt [3];
      bit          empty;
      res = '0;
      lo[0] = r.coord_x;    lo[1] = r.coord_y;    lo[2] = r.coord_z;
      hi[0] = r.box_high_x; hi[1] = r.box_high_y; hi[2] = r.box_high_z;
      empty = 1'b0;
      case (r.opcode)
         tws_pkg::OP_READ:  res.read_value = slot_mem[slot_of(lo[0], lo[1], lo[2])];
         tws_pkg::OP_WRITE: slot_mem[slot_of(lo[0], lo[1], lo[2])] = r.write_value;
         tws_pkg::OP_FILL: begin
            for (int d = 0; d < 3; d++) begin
               if (lo[d] > hi[d]) begin
                  empty = 1'b1;
               end else begin
                  cnt[d] = hi[d] - lo[d] + 1;
                  if (cnt[d] > (1 << eff_lg(d))) cnt[d] = 1 << eff_lg(d);
                  st[d] = lo[d];
               end
            end
            if (!empty) paint_box(st, cnt, r.write_value);
         end
         tws_pkg::OP_SHIFT: slide_window(lo);
         tws_pkg::OP_MOVE: begin
            for (int d = 0; d < 3; d++) amt[d] = 16'(lo[d] - origin[d]);
            slide_window(amt);
         end
         default: ;
      endcase
      res.origin_x = origin[0];
      res.origin_y = origin[1];
      res.origin_z = origin[2];
      return res;
   endfunction

   // Short gaps mostly, a few long ones.
   function automatic int unsigned gap_len();
      if (no_gaps) return 0;
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                          : $urandom_range(0, 2);
   endfunction

   // Offer one item and hold it until accepted; predict at acceptance.
   // Valid drops only when a gap follows, so back-to-back items keep it high.
   task automatic send_item(tws_pkg::req_type r);
      int unsigned g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(window_op(r));
   endtask

   // Directed rows whose result is obvious get it typed in and compared
   // against the predictor as well.
   task automatic send_known(tws_pkg::req_type r, tws_pkg::rsp_type want);
      tws_pkg::rsp_type p;
      send_item(r);
      p = pending_rsp[$];
      if (p !== want) begin
         err_count++;
         if (err_count <= 10)
            $display("table row mismatch: typed %h predicted %h", want, p);
      end
   endtask

   task automatic write_csr(tws_pkg::csr_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         tws_pkg::CSR_SIZE_X:  size_reg[0] = value[2:0];
         tws_pkg::CSR_SIZE_Y:  size_reg[1] = value[2:0];
         tws_pkg::CSR_SIZE_Z:  size_reg[2] = value[2:0];
         tws_pkg::CSR_DEFAULT: clear_value = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Drop valid, drain all outstanding results, then let a full walk time pass.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8400) @(posedge clock);
   endtask

   function automatic tws_pkg::req_type make_req(tws_pkg::op_type op, int unsigned x,
                                                 int unsigned y, int unsigned z,
                                                 int unsigned hx, int unsigned hy,
                                                 int unsigned hz, logic [31:0] v);
      tws_pkg::req_type r;
      r.opcode = op;
      r.coord_x = 16'(x);     r.coord_y = 16'(y);     r.coord_z = 16'(z);
      r.box_high_x = 16'(hx); r.box_high_y = 16'(hy); r.box_high_z = 16'(hz);
      r.write_value = v;
      return r;
   endfunction

   // Random item; mostly small coordinates near the origin so reads hit
   // written slots, with full-range noise mixed in.
   function automatic tws_pkg::req_type rand_req();
      tws_pkg::req_type r;
      int unsigned sel;
      r = tws_pkg::req_type'({$urandom, $urandom, $urandom, $urandom});
      sel = $urandom_range(0, 99);
      if (sel < 30)      r.opcode = tws_pkg::OP_READ;
      else if (sel < 55) r.opcode = tws_pkg::OP_WRITE;
      else if (sel < 70) r.opcode = tws_pkg::OP_FILL;
      else if (sel < 82) r.opcode = tws_pkg::OP_SHIFT;
      else if (sel < 92) r.opcode = tws_pkg::OP_MOVE;
      else               r.opcode = tws_pkg::op_type'(3'($urandom_range(5, 7)));
      if ($urandom_range(0, 3) != 0) begin
         r.coord_x = 16'(origin[0] + $urandom_range(0, 20));
         r.coord_y = 16'(origin[1] + $urandom_range(0, 20));
         r.coord_z = 16'(origin[2] + $urandom_range(0, 20));
         r.box_high_x = 16'(r.coord_x + $urandom_range(0, 6) - 1);
         r.box_high_y = 16'(r.coord_y + $urandom_range(0, 6));
         r.box_high_z = 16'(r.coord_z + $urandom_range(0, 4));
         if (r.opcode == tws_pkg::OP_SHIFT) begin
            r.coord_x = 16'($urandom_range(0, 18));
            r.coord_y = 16'($urandom_range(0, 18));
            r.coord_z = 16'($urandom_range(0, 18));
         end
      end
      return r;
   endfunction

   // Result checker: compare every accepted result with the oldest entry.
   always @(posedge clock) begin
      tws_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.read_value !== want.read_value ||
                rsp_data.origin_x !== want.origin_x ||
                rsp_data.origin_y !== want.origin_y ||
                rsp_data.origin_z !== want.origin_z) begin
               err_count++;
               if (err_count <= 10)
                  $display("result mismatch: expected %h got %h", want, rsp_data);
            end
         end
      end
   end

   // Receiver: random stalls, none during back-to-back stretches, or a long hold-off while the sender pushes on.
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (no_gaps) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_MAX) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      tws_pkg::req_type r;
      tws_pkg::rsp_type k;
      for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
      for (int d = 0; d < 3; d++) origin[d] = '0;
      size_reg[0] = 3'd4; size_reg[1] = 3'd4; size_reg[2] = 3'd0;
      clear_value = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table: after reset, extremes, every opcode, special cases.
      k = '0;
      send_known(make_req(tws_pkg::OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0), k);
      send_known(make_req(tws_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), k);
      k.read_value = 32'hFFFF_FFFF;
      send_known(make_req(tws_pkg::OP_READ, 16'h0010, 16'h0010, 16'h1234, 0, 0, 0, 0), k);
      k = '0;
      send_known(make_req(tws_pkg::op_type'(3'd5), 1, 2, 3, 4, 5, 6, 32'h1), k);
      send_known(make_req(tws_pkg::op_type'(3'd7), 16'hFFFF, 0, 0, 0, 0, 0,
                          32'hFFFF_FFFF), k);
      // empty box on z alone
      send_known(make_req(tws_pkg::OP_FILL, 0, 0, 5, 3, 3, 4, 32'hAAAA_5555), k);
      send_item(make_req(tws_pkg::OP_FILL, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         32'h5555_AAAA));
      send_item(make_req(tws_pkg::OP_READ, 7, 9, 0, 0, 0, 0, 0));
      send_item(make_req(tws_pkg::OP_FILL, 16'hFFFE, 3, 0, 16'hFFFF, 5, 0, 32'h0BAD_F00D));
      send_item(make_req(tws_pkg::OP_READ, 16'hFFFF, 4, 0, 0, 0, 0, 0));
      k.origin_x = 16'd3; k.origin_y = 16'hFFFF;
      send_known(make_req(tws_pkg::OP_SHIFT, 3, 16'hFFFF, 0, 0, 0, 0, 0), k);
      send_item(make_req(tws_pkg::OP_READ, 2, 2, 0, 0, 0, 0, 0));
      k = '0;
      send_known(make_req(tws_pkg::OP_MOVE, 0, 0, 0, 0, 0, 0, 0), k);
      send_item(make_req(tws_pkg::OP_SHIFT, 0, 0, 0, 0, 0, 0, 0));
      wait_idle();

      // Oversized extents, 3-D window, nonzero clearing value.
      write_csr(tws_pkg::CSR_SIZE_X, 32'd7);
      write_csr(tws_pkg::CSR_SIZE_Y, 32'd0);
      write_csr(tws_pkg::CSR_SIZE_Z, 32'd6);
      write_csr(tws_pkg::CSR_DEFAULT, 32'hFFFF_FFFF);
      send_item(make_req(tws_pkg::OP_FILL, 0, 0, 0, 15, 0, 15, 32'h1357_9BDF));
      send_item(make_req(tws_pkg::OP_SHIFT, 16'hFFFF, 1, 2, 0, 0, 0, 0));
      send_item(make_req(tws_pkg::OP_READ, 3, 0, 5, 0, 0, 0, 0));
      send_item(make_req(tws_pkg::OP_MOVE, 16'h8000, 16'hFFFF, 16'h0003, 0, 0, 0, 0));
      send_item(make_req(tws_pkg::OP_READ, 16'h8001, 0, 4, 0, 0, 0, 0));
      wait_idle();

      // Random phases under varying settings; the last phase holds the
      // receiver off for a long time so the block fills and stalls input.
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(tws_pkg::CSR_SIZE_X, $urandom_range(0, 7));
         write_csr(tws_pkg::CSR_SIZE_Y, $urandom_range(0, 7));
         write_csr(tws_pkg::CSR_SIZE_Z, (ph == 0) ? 0 : $urandom_range(0, 3));
         write_csr(tws_pkg::CSR_DEFAULT, $urandom);
         no_gaps = (ph == 2);
         for (int n = 0; n < 310; n++) begin
            if (ph == 5 && n == 100) begin
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (400) @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
            r = rand_req();
            send_item(r);
         end
         no_gaps = 1'b0;
         wait_idle();
      end

      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/tws_pkg.sv
sv/tws_ram.sv
sv/toroidal_window_store.sv
tb/testbench.sv
